// ===== sv/fcv_pkg.sv =====
// shared types, constants and register codes of the centred fir convolution block
package fcv_pkg;

    // fixed field widths
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_W      = 16;
    localparam int FILT_W      = 35;
    localparam int NUM_COEF    = 7;
    localparam int MAX_TAPS    = 7;
    localparam int TAP_W       = 3;
    localparam int RES_CNT_W   = 3;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = 4'd7;

    localparam logic [TAP_W-1:0]         TAP_COUNT_RESET = 3'd1;
    localparam logic signed [COEF_W-1:0] COEF_0_RESET    = 16'sd8192;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          final_sample;
    } t_in_word;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic                     series_end;
        logic                     too_short;
    } t_out_word;

    // what the output sequencer needs to know about one input word
    typedef struct packed {
        logic [RES_CNT_W-1:0] res_cnt;
        logic                 use_dot;
        logic                 last_in;
        logic                 too_short;
    } t_seq_ctrl;

endpackage

// ===== sv/fcv_cfg.sv =====
// configuration registers: tap count and kernel coefficients
module fcv_cfg #(
    parameter int DEPTH = fcv_pkg::MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [fcv_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [fcv_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [fcv_pkg::TAP_W-1:0]           o_taps,
    output logic signed [fcv_pkg::COEF_W-1:0]   o_coef [fcv_pkg::NUM_COEF]
);

    localparam int TW   = fcv_pkg::TAP_W;
    localparam int CW   = fcv_pkg::COEF_W;
    localparam int CI_W = $clog2(fcv_pkg::NUM_COEF);

    logic [TW-1:0]        r_tap_count;
    logic signed [CW-1:0] r_coef [fcv_pkg::NUM_COEF];
    logic [CI_W-1:0]      coef_sel;

    assign coef_sel = CI_W'(i_cfg_idx - fcv_pkg::REG_COEF_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= fcv_pkg::TAP_COUNT_RESET;
            for (int c = 0; c < fcv_pkg::NUM_COEF; c++) begin
                r_coef[c] <= '0;
            end
            r_coef[0] <= fcv_pkg::COEF_0_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx) inside
                fcv_pkg::REG_TAP_COUNT: begin
                    r_tap_count <= i_cfg_data[TW-1:0];
                end
                [fcv_pkg::REG_COEF_0:fcv_pkg::REG_COEF_LAST]: begin
                    r_coef[coef_sel] <= i_cfg_data[CW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // zero taps act as one, more than the delay line holds is clipped
    always_comb begin
        if (r_tap_count == '0) begin
            o_taps = TW'(1);
        end else if (int'(r_tap_count) > DEPTH) begin
            o_taps = TW'(DEPTH);
        end else begin
            o_taps = r_tap_count;
        end
    end

    assign o_coef = r_coef;

endmodule

// ===== sv/fcv_front.sv =====
// delay line, sample count and registered tap products
module fcv_front #(
    parameter int DEPTH = fcv_pkg::MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_acc,
    input  fcv_pkg::t_in_word                   i_word,
    input  logic [fcv_pkg::TAP_W-1:0]           i_taps,
    input  logic signed [fcv_pkg::COEF_W-1:0]   i_coef [fcv_pkg::NUM_COEF],
    input  logic                                i_adv,
    output logic                                o_s1_valid,
    output logic signed [fcv_pkg::FILT_W-1:0]   o_prod [DEPTH],
    output fcv_pkg::t_seq_ctrl                  o_ctrl
);

    localparam int SB    = fcv_pkg::SAMPLE_BITS;
    localparam int FW    = fcv_pkg::FILT_W;
    localparam int PW    = SB + fcv_pkg::COEF_W;
    localparam int AW    = (PW > FW) ? PW : FW;
    localparam int RCW   = fcv_pkg::RES_CNT_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic signed [SB-1:0] r_delay [DEPTH];
    logic signed [SB-1:0] win     [DEPTH];
    logic [CNT_W-1:0]     r_seen;
    logic                 r_s1_valid;
    logic signed [FW-1:0] r_prod  [DEPTH];
    logic signed [FW-1:0] n_prod  [DEPTH];
    fcv_pkg::t_seq_ctrl   r_ctrl;
    fcv_pkg::t_seq_ctrl   n_ctrl;

    // newest sample first, then the stored ones
    always_comb begin
        win[0] = i_word.sample;
        for (int m = 1; m < DEPTH; m++) begin
            win[m] = r_delay[m-1];
        end
    end

    // one multiplier per tap; tap t sees window position k-1-t
    for (genvar t = 0; t < DEPTH; t++) begin : g_lane
        logic signed [SB-1:0] sel;
        logic signed [PW-1:0] prod;
        logic signed [AW-1:0] ext;

        always_comb begin
            sel = '0;
            for (int m = 0; m < DEPTH; m++) begin
                if (m + t + 1 == int'(i_taps)) begin
                    sel = win[m];
                end
            end
        end

        assign prod      = i_coef[t] * sel;
        assign ext       = AW'(prod);
        assign n_prod[t] = ext[FW-1:0];
    end

    // how many results this word releases and what they carry
    always_comb begin
        int ki;
        int ri;
        int ii;
        ki = int'(i_taps);
        ri = ki - 1 - (ki >> 1);
        ii = int'(r_seen);
        n_ctrl.use_dot   = (ii >= ri) && (ii + 1 >= ki);
        n_ctrl.last_in   = i_word.final_sample;
        n_ctrl.too_short = i_word.final_sample && (ii + 1 < ki);
        if (i_word.final_sample) begin
            n_ctrl.res_cnt = (ii >= ri) ? RCW'(ri + 1) : RCW'(ii + 1);
        end else begin
            n_ctrl.res_cnt = (ii >= ri) ? RCW'(1) : RCW'(0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_seen     <= '0;
        end else if (i_acc) begin
            r_s1_valid <= (n_ctrl.res_cnt != '0);
            if (i_word.final_sample) begin
                r_seen <= '0;
            end else if (r_seen != CNT_MAX) begin
                r_seen <= r_seen + CNT_W'(1);
            end
        end else if (i_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // window samples older than the series are never used, so no clear here
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_delay <= win;
            r_prod  <= n_prod;
            r_ctrl  <= n_ctrl;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_prod     = r_prod;
    assign o_ctrl     = r_ctrl;

endmodule

// ===== sv/fcv_out.sv =====
// product sum and output register with border flush sequencing
module fcv_out #(
    parameter int DEPTH = fcv_pkg::MAX_TAPS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s1_valid,
    input  logic signed [fcv_pkg::FILT_W-1:0]   i_prod [DEPTH],
    input  fcv_pkg::t_seq_ctrl                  i_ctrl,
    input  logic                                i_stall,
    output logic                                o_load,
    output logic                                o_valid,
    output fcv_pkg::t_out_word                  o_word
);

    localparam int FW  = fcv_pkg::FILT_W;
    localparam int RCW = fcv_pkg::RES_CNT_W;
    localparam logic [RCW-1:0] ONE = RCW'(1);

    logic signed [FW-1:0] sum;
    logic                 r_valid;
    logic [RCW-1:0]       r_left;
    logic                 r_last_in;
    logic                 r_ts;
    fcv_pkg::t_out_word   r_word;
    logic                 free;

    always_comb begin
        sum = '0;
        for (int t = 0; t < DEPTH; t++) begin
            sum = sum + i_prod[t];
        end
    end

    assign free   = !r_valid || (!i_stall && r_left == '0);
    assign o_load = free && i_s1_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
        end else if (o_load) begin
            r_valid          <= 1'b1;
            r_left           <= i_ctrl.res_cnt - ONE;
            r_last_in        <= i_ctrl.last_in;
            r_ts             <= i_ctrl.too_short;
            r_word.filtered  <= i_ctrl.use_dot ? sum : '0;
            r_word.series_end <= i_ctrl.last_in && (i_ctrl.res_cnt == ONE);
            r_word.too_short <= i_ctrl.too_short && (i_ctrl.res_cnt == ONE);
        end else if (r_valid && !i_stall) begin
            if (r_left != '0) begin
                // trailing border words are zero
                r_left            <= r_left - ONE;
                r_word.filtered   <= '0;
                r_word.series_end <= r_last_in && (r_left == ONE);
                r_word.too_short  <= r_ts && (r_left == ONE);
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== sv/fir_convolution_1d.sv =====
// top level of the streaming centred fir convolution block
// One signed sample enters per word and the block returns one result word
// per sample, in order: the centred dot product of the kernel (K taps,
// Q2.13 coefficients) with the sample window, scaled by 2^13 and kept at
// full 35-bit precision, or zero at border positions. A sample is taken
// every clock while no border flush is running and the output is not
// stalled; its result is registered first as tap products, then after the
// adder tree in the output register. The sample marked final releases
// all outputs still pending for its series, up to floor((K-1)/2)+1 words,
// and during that flush the input is stalled. The final word of a series
// carries series_end, plus too_short when the series held fewer samples
// than taps (then all its results are zero). Configuration is taken on
// any clock with the write enable high and must only change between
// series while the block is empty.
module fir_convolution_1d #(
    parameter int MAX_TAPS = fcv_pkg::MAX_TAPS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // sample channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  fcv_pkg::t_in_word               i_in_word,
    // result channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output fcv_pkg::t_out_word              o_out_word,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [fcv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fcv_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    // delay line depth, never more than the coefficients on offer
    localparam int DEPTH = (MAX_TAPS > fcv_pkg::NUM_COEF) ? fcv_pkg::NUM_COEF : MAX_TAPS;

    logic [fcv_pkg::TAP_W-1:0]          taps;
    logic signed [fcv_pkg::COEF_W-1:0]  coef [fcv_pkg::NUM_COEF];
    logic                               in_acc;
    logic                               s1_valid;
    logic signed [fcv_pkg::FILT_W-1:0]  prod [DEPTH];
    fcv_pkg::t_seq_ctrl                 ctrl;
    logic                               out_load;

    // input stage can refill only when it is empty or its word moves on to the output
    assign o_stall = s1_valid && !out_load;
    assign in_acc  = i_valid && !o_stall;

    fcv_cfg #(
        .DEPTH (DEPTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_taps     (taps),
        .o_coef     (coef)
    );

    // shift in the sample, work out the products and the result count
    fcv_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (in_acc),
        .i_word     (i_in_word),
        .i_taps     (taps),
        .i_coef     (coef),
        .i_adv      (out_load),
        .o_s1_valid (s1_valid),
        .o_prod     (prod),
        .o_ctrl     (ctrl)
    );

    // sum the products and sequence the flush words
    fcv_out #(
        .DEPTH (DEPTH)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_prod     (prod),
        .i_ctrl     (ctrl),
        .i_stall    (i_stall),
        .o_load     (out_load),
        .o_valid    (o_valid),
        .o_word     (o_out_word)
    );

    // a held output word blocks the input stage behind it
    a_stall_backs_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && o_valid && i_stall |-> o_stall)
        else $error("input not stalled while the output is held");

    // a too_short word closes its series and carries a zero result
    a_short_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_word.too_short |-> o_out_word.series_end
                                            && o_out_word.filtered == '0)
        else $error("too_short word carries data or is not the last one");

    // reset empties the output register and the input stage
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !s1_valid)
        else $error("pipeline not empty after reset");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the streaming centred fir convolution block
`timescale 1ns / 1ps

module tb_top;

    localparam int CLK_HALF      = 10;
    localparam int LIMIT_CYCLES  = 200000;
    // covers the pipeline plus margin, used before register writes and at the end
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_WORDS  = 200;
    localparam int MAX_REPORTS   = 10;
    localparam logic [3:0] SEEN_MAX = 4'd15;

    // indexes past the last coefficient, writes there must be ignored
    localparam logic [fcv_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = fcv_pkg::REG_COEF_LAST + 1'b1;
    localparam logic [fcv_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    localparam logic signed [fcv_pkg::COEF_W-1:0] VAL_MAX = 16'sh7fff;
    localparam logic signed [fcv_pkg::COEF_W-1:0] VAL_MIN = 16'sh8000;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    fcv_pkg::t_in_word              in_word;
    logic                           out_valid;
    logic                           out_stall;
    fcv_pkg::t_out_word             out_word;
    logic                           cfg_we;
    logic [fcv_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [fcv_pkg::CFG_DATA_W-1:0] cfg_data;

    // predictor state: sample history, newest at index 0, and series position
    logic signed [fcv_pkg::SAMPLE_BITS-1:0] hist [fcv_pkg::NUM_COEF];
    logic [3:0]                             seen_cnt;
    logic [fcv_pkg::TAP_W-1:0]              taps_reg;
    logic signed [fcv_pkg::COEF_W-1:0]      coef_reg [fcv_pkg::NUM_COEF];

    // filter outputs still owed by the block, oldest first
    fcv_pkg::t_out_word pending_results[$];

    int  mismatches;
    int  words_sent;
    int  cycle_cnt;
    int  stall_left;
    bit  tx_gaps;
    bit  rx_gaps;

    fir_convolution_1d u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_stall    (in_stall),
        .i_in_word  (in_word),
        .o_valid    (out_valid),
        .i_stall    (out_stall),
        .o_out_word (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // a finished series leaves an empty window and a fresh count
    function automatic void clear_window();
        for (int t = 0; t < fcv_pkg::NUM_COEF; t++) begin
            hist[t] = '0;
        end
        seen_cnt = '0;
    endfunction

    function automatic void kernel_reset();
        taps_reg = fcv_pkg::TAP_COUNT_RESET;
        for (int t = 0; t < fcv_pkg::NUM_COEF; t++) begin
            coef_reg[t] = '0;
        end
        coef_reg[0] = fcv_pkg::COEF_0_RESET;
        clear_window();
    endfunction

    function automatic void apply_reg(logic [fcv_pkg::CFG_IDX_W-1:0]  idx,
                                      logic [fcv_pkg::CFG_DATA_W-1:0] data);
        if (idx == fcv_pkg::REG_TAP_COUNT) begin
            taps_reg = data[fcv_pkg::TAP_W-1:0];
        end else if (idx >= fcv_pkg::REG_COEF_0 && idx <= fcv_pkg::REG_COEF_LAST) begin
            coef_reg[idx - fcv_pkg::REG_COEF_0] = data;
        end
        // anything past the last coefficient is dropped
    endfunction

    // shift one sample in and queue the outputs it releases
    function automatic void fir_predict(fcv_pkg::t_in_word w);
        int                                k;
        int                                r;
        int                                pos;
        int                                first;
        longint                            acc;
        logic signed [fcv_pkg::FILT_W-1:0] dot;
        fcv_pkg::t_out_word                res;
        // zero taps behaves as one tap, and never more than the delay line holds
        k = (taps_reg == '0) ? 1 : int'(taps_reg);
        if (k > fcv_pkg::MAX_TAPS) begin
            k = fcv_pkg::MAX_TAPS;
        end
        // r is the number of taps right of centre, i.e. the output lag
        r   = k - 1 - k / 2;
        pos = int'(seen_cnt);
        for (int t = fcv_pkg::NUM_COEF - 1; t > 0; t--) begin
            hist[t] = hist[t-1];
        end
        hist[0] = w.sample;
        // window only complete once k samples of this series are in
        acc = 0;
        if (pos + 1 >= k) begin
            for (int t = 0; t < k; t++) begin
                acc += longint'(coef_reg[t]) * longint'(hist[k-1-t]);
            end
        end
        dot = acc[fcv_pkg::FILT_W-1:0];
        if (!w.final_sample) begin
            if (pos >= r) begin
                res.filtered   = dot;
                res.series_end = 1'b0;
                res.too_short  = 1'b0;
                pending_results.push_back(res);
            end
            if (seen_cnt < SEEN_MAX) begin
                seen_cnt++;
            end
        end else begin
            // last sample flushes the lagging outputs, the right border is zero
            first = (pos >= r) ? pos - r : 0;
            for (int j = first; j <= pos; j++) begin
                res.filtered   = (pos >= r && j == pos - r) ? dot : '0;
                res.series_end = (j == pos);
                res.too_short  = (j == pos) && (pos + 1 < k);
                pending_results.push_back(res);
            end
            clear_window();
        end
    endfunction

    // ------------------------------------------------------------------
    // monitor: predict on input words, check output words, track writes
    // prediction goes first so the order within an edge never matters
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        fcv_pkg::t_out_word want;
        if (!rst_n) begin
            kernel_reset();
            pending_results.delete();
        end else begin
            if (in_valid && !in_stall) begin
                fir_predict(in_word);
            end
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("unexpected output word: filtered %0d end %0b short %0b",
                                 out_word.filtered, out_word.series_end, out_word.too_short);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (out_word.filtered !== want.filtered
                            || out_word.series_end !== want.series_end
                            || out_word.too_short !== want.too_short) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch exp: filtered %0d end %0b short %0b",
                                     want.filtered, want.series_end, want.too_short);
                            $display("         got: filtered %0d end %0b short %0b",
                                     out_word.filtered, out_word.series_end,
                                     out_word.too_short);
                        end
                    end
                end
            end
            if (cfg_we) begin
                apply_reg(cfg_idx, cfg_data);
            end
        end
    end

    // output side back-pressure: stalls come in random bursts
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_stall = 1'b1;
            stall_left--;
        end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            out_stall  = 1'b1;
            stall_left = $urandom_range(1, 4) - 1;
        end else begin
            out_stall = 1'b0;
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic fcv_pkg::t_in_word mk_word(logic signed [fcv_pkg::SAMPLE_BITS-1:0] s,
                                                  logic fin);
        fcv_pkg::t_in_word w;
        w.sample       = s;
        w.final_sample = fin;
        return w;
    endfunction

    // mostly full-range values, with the extremes and tiny values mixed in
    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 9))
            0: begin
                return VAL_MAX;
            end
            1: begin
                return VAL_MIN;
            end
            2: begin
                return 16'($urandom_range(0, 16) - 8);
            end
            default: begin
                return 16'($urandom);
            end
        endcase
    endfunction

    // one sample word; valid stays up between back-to-back words
    task automatic send_word(input fcv_pkg::t_in_word w);
        int gap;
        if (tx_gaps && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_word  = w;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        words_sent++;
    endtask

    task automatic send_series(input int len);
        for (int n = 0; n < len; n++) begin
            send_word(mk_word(rand_value(), n == len - 1));
        end
    endtask

    // sender holds off until every owed word is out, then lets the pipe settle
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fcv_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [fcv_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_kernel(input logic [fcv_pkg::TAP_W-1:0] taps,
                               input logic [fcv_pkg::NUM_COEF-1:0][fcv_pkg::COEF_W-1:0] c);
        write_reg(fcv_pkg::REG_TAP_COUNT, fcv_pkg::CFG_DATA_W'(taps));
        for (int t = 0; t < fcv_pkg::NUM_COEF; t++) begin
            write_reg(fcv_pkg::REG_COEF_0 + fcv_pkg::CFG_IDX_W'(t), c[t]);
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // out of reset the kernel is a single unity tap, so samples pass scaled
    task automatic test_reset_kernel();
        send_word(mk_word(VAL_MAX, 1'b0));
        send_word(mk_word(VAL_MIN, 1'b1));
        // one-word series
        send_word(mk_word(-16'sd1, 1'b1));
        drain();
    endtask

    // seven taps at full scale, both signs of the largest sum
    task automatic test_full_scale();
        logic [fcv_pkg::NUM_COEF-1:0][fcv_pkg::COEF_W-1:0] c;
        for (int t = 0; t < fcv_pkg::NUM_COEF; t++) begin
            c[t] = VAL_MIN;
        end
        load_kernel(fcv_pkg::TAP_W'(fcv_pkg::MAX_TAPS), c);
        for (int n = 0; n < fcv_pkg::MAX_TAPS; n++) begin
            send_word(mk_word(VAL_MIN, n == fcv_pkg::MAX_TAPS - 1));
        end
        drain();
        for (int t = 0; t < fcv_pkg::NUM_COEF; t++) begin
            c[t] = VAL_MAX;
        end
        load_kernel(fcv_pkg::TAP_W'(fcv_pkg::MAX_TAPS), c);
        for (int n = 0; n < fcv_pkg::MAX_TAPS; n++) begin
            send_word(mk_word(VAL_MIN, n == fcv_pkg::MAX_TAPS - 1));
        end
        drain();
    endtask

    // tap count of zero acts as one tap; writes past the last coefficient do nothing
    task automatic test_zero_taps();
        write_reg(fcv_pkg::REG_TAP_COUNT, '0);
        write_reg(REG_SPARE_LO, '1);
        write_reg(REG_SPARE_HI, '1);
        send_word(mk_word(16'sd1234, 1'b0));
        send_word(mk_word(-16'sd77, 1'b1));
        drain();
    endtask

    // series one shorter than the kernel: all zeros and a too-short flag
    task automatic test_short_series();
        logic [fcv_pkg::NUM_COEF-1:0][fcv_pkg::COEF_W-1:0] c;
        for (int t = 0; t < fcv_pkg::NUM_COEF; t++) begin
            c[t] = rand_value();
        end
        load_kernel(fcv_pkg::TAP_W'(5), c);
        send_series(4);
        drain();
    endtask

    // random kernels and series lengths, long series push the count into saturation
    task automatic test_random_streams();
        logic [fcv_pkg::NUM_COEF-1:0][fcv_pkg::COEF_W-1:0] c;
        logic [fcv_pkg::TAP_W-1:0]                         taps;
        int                                                base;
        int                                                phase;
        int                                                pick;
        bit                                                quiet;
        base  = words_sent;
        phase = 0;
        while (words_sent - base < RANDOM_WORDS) begin
            // the closing stretch runs with no idling on either side
            quiet   = (words_sent - base) >= RANDOM_WORDS - 40;
            tx_gaps = !quiet && ($urandom_range(0, 3) != 0);
            rx_gaps = !quiet && ($urandom_range(0, 3) != 0);
            case (phase)
                0: begin
                    taps = fcv_pkg::TAP_W'(fcv_pkg::MAX_TAPS);
                end
                1: begin
                    taps = '0;
                end
                2: begin
                    taps = fcv_pkg::TAP_W'(1);
                end
                default: begin
                    taps = fcv_pkg::TAP_W'($urandom_range(0, fcv_pkg::MAX_TAPS));
                end
            endcase
            for (int t = 0; t < fcv_pkg::NUM_COEF; t++) begin
                c[t] = rand_value();
            end
            load_kernel(taps, c);
            repeat ($urandom_range(2, 5)) begin
                pick = $urandom_range(0, 9);
                if (pick < 7) begin
                    send_series($urandom_range(1, 8));
                end else if (pick < 9) begin
                    send_series($urandom_range(9, 15));
                end else begin
                    send_series($urandom_range(16, 24));
                end
            end
            drain();
            phase++;
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_word    = '0;
        out_stall  = 1'b0;
        cfg_we     = 1'b0;
        cfg_idx    = '0;
        cfg_data   = '0;
        mismatches = 0;
        words_sent = 0;
        cycle_cnt  = 0;
        stall_left = 0;
        tx_gaps    = 1'b1;
        rx_gaps    = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_kernel();
        test_full_scale();
        test_zero_taps();
        test_short_series();
        test_random_streams();

        drain();
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fcv_pkg.sv
sv/fcv_cfg.sv
sv/fcv_front.sv
sv/fcv_out.sv
sv/fir_convolution_1d.sv
tb/tb_top.sv
